// ===== hdl/rkc_pkg.sv =====
// Shared types, codes and helpers for the RGB keyframe crossfade block.
// No dependencies; imported by rkc_lane and rgb_keyframe_crossfade.
package rkc_pkg;

  // Default sizing
  localparam int LED_COUNT_DEF   = 16;
  localparam int FRAME_DEPTH_DEF = 256;

  // Register reset values
  localparam logic [15:0] STEP_LIMIT_RST = 16'd400;
  localparam logic [7:0]  CAP_RST        = 8'd200;
  localparam logic [8:0]  FRAMES_RST     = 9'd2;

  // Register indexes on the config port
  localparam logic [1:0] REG_STEP_LIMIT = 2'd0;
  localparam logic [1:0] REG_CAP        = 2'd1;
  localparam logic [1:0] REG_FRAMES     = 2'd2;

  // Input item kinds
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // Main sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ST_RD,
    S_ST_WR,
    S_AD_RD0,
    S_AD_RD1,
    S_AD_WR,
    S_CMP_RD,
    S_CMP_GO,
    S_CMP_WAIT,
    S_EMIT
  } state_t;

  // Per-channel interpolation unit states
  typedef enum logic [1:0] {
    L_IDLE,
    L_MUL,
    L_DIV
  } lane_state_t;

  // Status of one interpolation lane
  typedef struct packed {
    logic       busy;
    logic [7:0] value;
  } lane_stat_t;

  // Cap each 8-bit channel of a packed RGB word
  function automatic logic [23:0] clamp_word(input logic [23:0] w, input logic [7:0] cap);
    logic [23:0] r;
    r = w;
    if (w[23:16] >= cap) r[23:16] = cap;
    if (w[15:8] >= cap)  r[15:8]  = cap;
    if (w[7:0] >= cap)   r[7:0]   = cap;
    return r;
  endfunction

endpackage

// ===== hdl/rgb_keyframe_crossfade.sv =====
// Top level of the RGB keyframe crossfade block: config registers, keyframe
// and color memories, frame sequencer and three rkc_lane units; uses rkc_pkg.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tdata led_index,frame_index,color_word
//           |           |                    | tuser mode
//  m_*      | out       | m_tvalid/m_tready  | tdata led,red,green,blue; tlast last
//  cfg_*    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A start does one table read and one color write per LED. A tick runs the serial
// multiply/divide in the lanes once per LED, plus two table reads and a color write
// per LED when the frame advances.
// Reset is synchronous; the color store reads as zero until reloaded, the keyframe
// table has no reset. A stalled m_tready holds the sequencer at the result stage.
module rgb_keyframe_crossfade
  import rkc_pkg::*;
#(
  parameter int LED_COUNT   = LED_COUNT_DEF,
  parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [3:0] led_index, [11:4] frame_index, [35:12] color_word
  input  logic [1:0]  s_tuser,   // [1:0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [3:0] led, [11:4] red, [19:12] green, [27:20] blue
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int LCW   = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int FW    = $clog2(FRAME_DEPTH);
  localparam int FCW   = $clog2(FRAME_DEPTH + 1);
  localparam int LW    = (FCW > 9) ? FCW : 9;
  localparam int FXW   = (FCW > 8) ? FCW : 8;
  localparam int DEPTH = LED_COUNT * FRAME_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  // Config registers
  logic [15:0] step_limit;
  logic [7:0]  brightness_cap;
  logic [8:0]  frames_in_use;

  // Sequence state
  state_t      state, state_next;
  logic [15:0] step_counter;
  logic [FW-1:0] frame_position;
  logic [FW-1:0] next_frame;
  logic        before_first;
  logic [LCW-1:0] led_cnt;
  logic [AW-1:0]  base;

  // Memories
  logic [23:0] keyframe_table [DEPTH];
  logic [47:0] color_mem [LED_COUNT];   // {current, target}
  logic        cm_valid [LED_COUNT];
  logic [23:0] tb_rd;
  logic [47:0] cm_rd;
  logic        cm_rd_ok;
  logic [23:0] cur_raw;
  logic [AW-1:0] tb_addr;
  logic        cm_we;
  logic [47:0] cm_wdata;
  logic [47:0] cm_eff;

  // Output register
  logic [3:0]  out_led;
  logic [7:0]  out_red, out_green, out_blue;

  // Input fields
  logic [1:0]  in_mode;
  logic [3:0]  in_led;
  logic [7:0]  in_frame;
  logic [23:0] in_color;
  logic        in_fire;
  logic        wr_ok;
  logic [AW+3:0] wr_full;

  // Tick and frame advance terms
  logic [16:0] cnt_inc;
  logic        wrap;
  logic [LW-1:0] fiu_x, frames_sat, lastf, pos_adv;
  logic [FW-1:0] pos_new, nf_new;

  logic        led_last;
  logic        out_free;
  lane_stat_t  st_r, st_g, st_b;
  logic        lanes_busy;
  logic        lane_start;

  assign in_mode  = s_tuser;
  assign in_led   = s_tdata[3:0];
  assign in_frame = s_tdata[11:4];
  assign in_color = s_tdata[35:12];

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = s_tvalid && s_tready;

  // Keyframe write decode, out-of-range writes dropped
  assign wr_full = (AW+4)'(in_led) * (AW+4)'(FRAME_DEPTH) + (AW+4)'(in_frame);
  assign wr_ok   = in_fire && (in_mode == MODE_WRITE)
                && ({3'd0, in_led} < 7'(LED_COUNT))
                && (FXW'(in_frame) < FXW'(FRAME_DEPTH));

  // Step counter test at 17 bits
  assign cnt_inc = {1'b0, step_counter} + 17'd1;
  assign wrap    = (cnt_inc > {1'b0, step_limit});

  // Frame advance with saturated frame count
  always_comb begin
    fiu_x = LW'(frames_in_use);
    if (fiu_x < LW'(2))                frames_sat = LW'(2);
    else if (fiu_x > LW'(FRAME_DEPTH)) frames_sat = LW'(FRAME_DEPTH);
    else                               frames_sat = fiu_x;
    lastf   = frames_sat - LW'(1);
    pos_adv = before_first ? '0 : (LW'(frame_position) + LW'(1));
    if (pos_adv < lastf) begin
      pos_new = FW'(pos_adv);
      nf_new  = FW'(pos_adv + LW'(1));
    end else if (pos_adv > lastf) begin
      pos_new = '0;
      nf_new  = FW'(1);
    end else begin
      pos_new = FW'(pos_adv);
      nf_new  = '0;
    end
  end

  assign led_last   = (led_cnt == LCW'(LED_COUNT - 1));
  assign out_free   = !m_tvalid || m_tready;
  assign lanes_busy = st_r.busy || st_g.busy || st_b.busy;
  assign lane_start = (state == S_CMP_GO);

  // Next state and table read address
  always_comb begin
    state_next = state;
    tb_addr    = base;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (in_mode)
            MODE_START: state_next = S_ST_RD;
            MODE_TICK:  state_next = wrap ? S_AD_RD0 : S_CMP_RD;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_ST_RD:  state_next = S_ST_WR;
      S_ST_WR:  state_next = led_last ? S_IDLE : S_ST_RD;
      S_AD_RD0: begin
        tb_addr    = base + AW'(frame_position);
        state_next = S_AD_RD1;
      end
      S_AD_RD1: begin
        tb_addr    = base + AW'(next_frame);
        state_next = S_AD_WR;
      end
      S_AD_WR:    state_next = led_last ? S_CMP_RD : S_AD_RD0;
      S_CMP_RD:   state_next = S_CMP_GO;
      S_CMP_GO:   state_next = S_CMP_WAIT;
      S_CMP_WAIT: if (!lanes_busy) state_next = S_EMIT;
      S_EMIT:     if (out_free) state_next = led_last ? S_IDLE : S_CMP_RD;
      default:    state_next = S_IDLE;
    endcase
  end

  // Color store write data: start loads black/raw target, advance loads capped pair
  assign cm_we    = (state == S_ST_WR) || (state == S_AD_WR);
  assign cm_wdata = (state == S_ST_WR) ? {24'd0, tb_rd}
                  : {clamp_word(cur_raw, brightness_cap), clamp_word(tb_rd, brightness_cap)};
  assign cm_eff   = cm_rd_ok ? cm_rd : 48'd0;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      step_limit     <= STEP_LIMIT_RST;
      brightness_cap <= CAP_RST;
      frames_in_use  <= FRAMES_RST;
      step_counter   <= 16'd0;
      frame_position <= '0;
      next_frame     <= '0;
      before_first   <= 1'b1;
      led_cnt        <= '0;
      base           <= '0;
      m_tvalid       <= 1'b0;
      for (int i = 0; i < LED_COUNT; i++) cm_valid[i] <= 1'b0;
    end else begin
      state <= state_next;

      // config transfer
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STEP_LIMIT: step_limit     <= cfg_data;
          REG_CAP:        brightness_cap <= cfg_data[7:0];
          REG_FRAMES:     frames_in_use  <= cfg_data[8:0];
          default:        ;
        endcase
      end

      // tick and start bookkeeping
      if (in_fire && in_mode == MODE_TICK) begin
        if (wrap) begin
          step_counter   <= 16'd0;
          frame_position <= pos_new;
          next_frame     <= nf_new;
          before_first   <= 1'b0;
        end else begin
          step_counter <= cnt_inc[15:0];
        end
      end
      if (in_fire && in_mode == MODE_START) begin
        before_first   <= 1'b1;
        frame_position <= '0;
      end

      if (cm_we) cm_valid[led_cnt] <= 1'b1;

      // LED walk
      if (cm_we) begin
        if (led_last) begin
          led_cnt <= '0;
          base    <= '0;
        end else begin
          led_cnt <= led_cnt + LCW'(1);
          base    <= base + AW'(FRAME_DEPTH);
        end
      end
      if (state == S_EMIT && out_free) begin
        led_cnt <= led_last ? '0 : (led_cnt + LCW'(1));
      end

      // output register handshake
      if (state == S_EMIT && out_free) m_tvalid <= 1'b1;
      else if (m_tready)               m_tvalid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      out_led   <= 4'(led_cnt);
      out_red   <= st_r.value;
      out_green <= st_g.value;
      out_blue  <= st_b.value;
      m_tlast   <= led_last;
    end
    if (state == S_AD_RD1) cur_raw <= tb_rd;
  end

  // Keyframe table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_ok) keyframe_table[wr_full[AW-1:0]] <= in_color;
    tb_rd <= keyframe_table[tb_addr];
  end

  // Current/target color store
  always_ff @(posedge clk) begin
    if (cm_we) color_mem[led_cnt] <= cm_wdata;
    cm_rd    <= color_mem[led_cnt];
    cm_rd_ok <= cm_valid[led_cnt];
  end

  assign m_tdata = {4'd0, out_blue, out_green, out_red, out_led};

  // One serial interpolator per channel
  rkc_lane u_lane_r (
    .clk   (clk),
    .rst   (rst),
    .start (lane_start),
    .now   (cm_eff[47:40]),
    .nxt   (cm_eff[23:16]),
    .step  (step_counter),
    .lim   (step_limit),
    .stat  (st_r)
  );

  rkc_lane u_lane_g (
    .clk   (clk),
    .rst   (rst),
    .start (lane_start),
    .now   (cm_eff[39:32]),
    .nxt   (cm_eff[15:8]),
    .step  (step_counter),
    .lim   (step_limit),
    .stat  (st_g)
  );

  rkc_lane u_lane_b (
    .clk   (clk),
    .rst   (rst),
    .start (lane_start),
    .now   (cm_eff[31:24]),
    .nxt   (cm_eff[7:0]),
    .step  (step_counter),
    .lim   (step_limit),
    .stat  (st_b)
  );

endmodule

// ===== hdl/rkc_lane.sv =====
// One color channel interpolator: now + floor(step * (next - now) / lim).
// Bit-serial shift-add multiply then restoring divide; uses rkc_pkg.
module rkc_lane
  import rkc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [7:0]  now,
  input  logic [7:0]  nxt,
  input  logic [15:0] step,
  input  logic [15:0] lim,
  output lane_stat_t  stat
);

  lane_state_t st, st_next;
  logic [2:0]  cnt;
  logic        neg;
  logic [7:0]  mag;
  logic [7:0]  now_r;
  logic [23:0] mcand;
  logic [23:0] acc;
  logic [15:0] rem;
  logic [7:0]  dvd;
  logic [7:0]  quo;
  logic [7:0]  value;

  logic [23:0] prod;
  logic [16:0] trial;
  logic [16:0] trial_sub;
  logic        ge;
  logic [7:0]  quo_fin;
  logic [15:0] rem_fin;

  // Multiply step: add the shifted multiplicand when the low bit is set
  assign prod      = acc + (mag[0] ? mcand : 24'd0);
  // Divide step: bring down one dividend bit and try the subtract
  assign trial     = {rem, dvd[7]};
  assign trial_sub = trial - {1'b0, lim};
  assign ge        = (trial >= {1'b0, lim});
  assign quo_fin   = {quo[6:0], ge};
  assign rem_fin   = ge ? trial_sub[15:0] : trial[15:0];

  // Next state: multiply over the 8 multiplier bits, then divide over the 8 dividend bits; zero limit skips both
  always_comb begin
    st_next = st;
    case (st)
      L_IDLE: begin
        if (start && (lim != 16'd0)) st_next = L_MUL;
      end
      L_MUL: begin
        if (cnt == 3'd7) st_next = L_DIV;
      end
      L_DIV: begin
        if (cnt == 3'd7) st_next = L_IDLE;
      end
      default: st_next = L_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= L_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // Serial multiply and divide datapath
  always_ff @(posedge clk) begin
    case (st)
      L_IDLE: begin
        if (start) begin
          if (lim == 16'd0) begin
            value <= now;
          end else begin
            neg   <= (nxt < now);
            mag   <= (nxt < now) ? (now - nxt) : (nxt - now);
            now_r <= now;
            mcand <= {8'd0, step};
            acc   <= 24'd0;
            cnt   <= 3'd0;
          end
        end
      end
      L_MUL: begin
        acc   <= prod;
        mcand <= {mcand[22:0], 1'b0};
        mag   <= {1'b0, mag[7:1]};
        cnt   <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          // quotient stays below 256, so the top 16 bits start below lim
          rem <= prod[23:8];
          dvd <= prod[7:0];
          quo <= 8'd0;
        end
      end
      L_DIV: begin
        rem <= rem_fin;
        dvd <= {dvd[6:0], 1'b0};
        quo <= quo_fin;
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          // step <= lim keeps the result between now and next: 8 bits suffice
          value <= neg ? (now_r - quo_fin - {7'd0, (rem_fin != 16'd0)})
                       : (now_r + quo_fin);
        end
      end
      default: ;
    endcase
  end

  assign stat.busy  = (st != L_IDLE);
  assign stat.value = value;

endmodule
